### rtl/integrating_input_debounce_top_defines.svh
// assertion macros for the integrating input debounce checker
`ifndef INTEGRATING_INPUT_DEBOUNCE_TOP_DEFINES_SVH
`define INTEGRATING_INPUT_DEBOUNCE_TOP_DEFINES_SVH

// check sampled on the rising clock edge, skipped while reset is held
`define IID_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check sampled on the rising clock edge, also live during reset
`define IID_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/iid_pkg.sv
// shared widths, register indexes and reset values for the debounce block
package iid_pkg;

    localparam int TIMER_W     = 32;
    localparam int WORD_W      = 24;
    localparam int WORD_IDX_W  = 5;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [WORD_W-1:0] HOLD_DEFAULT = 24'd500000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DIN_INVERT  = 3'd0,
        REG_DOUT_INVERT = 3'd1,
        REG_HOLD_BYTE0  = 3'd2,
        REG_HOLD_BYTE1  = 3'd3,
        REG_HOLD_BYTE2  = 3'd4
    } cfg_reg_t;

endpackage

### rtl/integrating_input_debounce_top.sv
// integrating debounce filter for a shifted i/o chain, integrators kept in a memory
//
// channel  dir  handshake             word layout (lowest bit first)
// s_       in   s_tvalid / s_tready   timer_count[31:0] raw_din[55:32] dout_data[79:56]
// m_       out  m_tvalid / m_tready   dout_tx[23:0] din_filtered[47:24]
// cfg_     in   cfg_wr_en             cfg_addr selects register, cfg_wdata is the value
//
// a word sweeps CHANNEL_BYTES*BITS_PER_BYTE bits (at most 24, 24 by default): the memory
//   has one read and one write port, so one bit is integrated a cycle unless m_ stalls
// the result is loaded into m_ as the last bit is written; the next word is taken in the
//   cycle the last bit of the current one is read, so words can run without a gap
// reset is synchronous; it clears registers, filter state and integrator valid bits
// a stalled result holds the sweep at its last bit, which also holds off s_tready
module integrating_input_debounce_top #(
    parameter int CHANNEL_BYTES = 3,
    parameter int BITS_PER_BYTE = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // timer_count, raw_din, dout_data
    input  logic [iid_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // dout_tx, din_filtered
    output logic [iid_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [iid_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [iid_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import iid_pkg::*;

    // positions beyond the word are never integrated and stay zero
    localparam int NPOS_RAW = CHANNEL_BYTES * BITS_PER_BYTE;
    localparam int NPOS     = (NPOS_RAW < WORD_W) ? NPOS_RAW : WORD_W;
    localparam int POS_W    = (NPOS > 1) ? $clog2(NPOS) : 1;
    localparam int BYTE_W   = (CHANNEL_BYTES > 1) ? $clog2(CHANNEL_BYTES) : 1;
    localparam int BIT_W    = (BITS_PER_BYTE > 1) ? $clog2(BITS_PER_BYTE) : 1;

    // configuration registers
    logic [WORD_W-1:0] din_inv_reg;
    logic [WORD_W-1:0] dout_inv_reg;
    logic [WORD_W-1:0] hold0_reg;
    logic [WORD_W-1:0] hold1_reg;
    logic [WORD_W-1:0] hold2_reg;

    // per-word history
    logic [WORD_W-1:0]  last_raw_reg;
    logic [TIMER_W-1:0] last_timer_reg;
    logic [WORD_W-1:0]  filt_reg;
    logic [WORD_W-1:0]  filt_next;

    // issue stage: walks the bit positions of the current word
    logic               s0_active_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [BYTE_W-1:0]  byte_cnt_reg;
    logic [BIT_W-1:0]   bit_cnt_reg;
    logic [TIMER_W-1:0] dt_reg;
    logic [WORD_W-1:0]  word_reg;
    logic [WORD_W-1:0]  dout_tx_reg;
    logic               s0_last;
    logic [WORD_W-1:0]  limit_sel;

    // update stage: one integrator read-modify-write
    logic               s1_valid_reg;
    logic [POS_W-1:0]   s1_pos_reg;
    logic               s1_bit_reg;
    logic [WORD_W-1:0]  s1_limit_reg;
    logic [TIMER_W-1:0] s1_dt_reg;
    logic               s1_last_reg;
    logic [WORD_W-1:0]  s1_dout_reg;

    // integrator memory
    logic [WORD_W-1:0]  integ_mem [NPOS];
    logic [NPOS-1:0]    integ_vld_reg;
    logic [WORD_W-1:0]  rd_data_reg;
    logic               rd_vld_reg;
    logic [POS_W-1:0]   rd_addr;
    logic               wr_en;
    logic               fwd;
    logic [WORD_W-1:0]  integ_cur;
    logic [WORD_W-1:0]  integ_new;
    logic [TIMER_W:0]   up_sum;
    logic               hit_limit;
    logic               hit_zero;

    // result register
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic accept;
    logic advance;
    logic out_block;

    // the sweep can only finish a word into a free or draining result register
    assign out_block = s1_valid_reg && s1_last_reg && m_tvalid_reg && !m_tready;
    assign advance   = !out_block;
    assign s0_last   = (pos_reg == POS_W'(NPOS - 1));
    assign s_tready  = advance && (!s0_active_reg || s0_last);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // per-byte hold limit, bytes past the third share the last limit
    always_comb begin
        priority if (byte_cnt_reg == BYTE_W'(0)) begin
            limit_sel = hold0_reg;
        end else if (byte_cnt_reg == BYTE_W'(1)) begin
            limit_sel = hold1_reg;
        end else begin
            limit_sel = hold2_reg;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            din_inv_reg  <= '0;
            dout_inv_reg <= '0;
            hold0_reg    <= HOLD_DEFAULT;
            hold1_reg    <= HOLD_DEFAULT;
            hold2_reg    <= HOLD_DEFAULT;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_DIN_INVERT:  din_inv_reg  <= cfg_wdata;
                REG_DOUT_INVERT: dout_inv_reg <= cfg_wdata;
                REG_HOLD_BYTE0:  hold0_reg    <= cfg_wdata;
                REG_HOLD_BYTE1:  hold1_reg    <= cfg_wdata;
                REG_HOLD_BYTE2:  hold2_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // issue stage control and history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_active_reg  <= 1'b0;
            pos_reg        <= '0;
            byte_cnt_reg   <= '0;
            bit_cnt_reg    <= '0;
            last_raw_reg   <= '0;
            last_timer_reg <= '0;
        end else if (accept) begin
            s0_active_reg  <= 1'b1;
            pos_reg        <= '0;
            byte_cnt_reg   <= '0;
            bit_cnt_reg    <= '0;
            last_raw_reg   <= s_tdata[TIMER_W +: WORD_W];
            last_timer_reg <= s_tdata[0 +: TIMER_W];
        end else if (advance && s0_active_reg) begin
            pos_reg <= pos_reg + POS_W'(1);
            if (bit_cnt_reg == BIT_W'(BITS_PER_BYTE - 1)) begin
                bit_cnt_reg  <= '0;
                byte_cnt_reg <= byte_cnt_reg + BYTE_W'(1);
            end else begin
                bit_cnt_reg <= bit_cnt_reg + BIT_W'(1);
            end
            if (s0_last) begin
                s0_active_reg <= 1'b0;
            end
        end
    end

    // per-word operands, captured on accept; the lag means the previous raw word is filtered
    always_ff @(posedge aclk) begin
        if (accept) begin
            dt_reg      <= s_tdata[0 +: TIMER_W] - last_timer_reg;
            word_reg    <= last_raw_reg ^ din_inv_reg;
            dout_tx_reg <= s_tdata[TIMER_W + WORD_W +: WORD_W] ^ dout_inv_reg;
        end
    end

    // update stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s0_active_reg;
        end
    end

    // update stage operands travel with the position, so words can overlap
    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_pos_reg   <= pos_reg;
            s1_bit_reg   <= word_reg[WORD_IDX_W'(pos_reg)];
            s1_limit_reg <= limit_sel;
            s1_dt_reg    <= dt_reg;
            s1_last_reg  <= s0_last;
            s1_dout_reg  <= dout_tx_reg;
        end
    end

    // while stalled the update stage entry is re-read so its data stays put
    assign rd_addr = advance ? pos_reg : s1_pos_reg;
    assign wr_en   = s1_valid_reg && advance;
    assign fwd     = wr_en && (s1_pos_reg == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            integ_mem[s1_pos_reg] <= integ_new;
        end
        rd_data_reg <= fwd ? integ_new : integ_mem[rd_addr];
    end

    // entries never written since reset read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_vld_reg <= '0;
            rd_vld_reg    <= 1'b0;
        end else begin
            if (wr_en) begin
                integ_vld_reg[s1_pos_reg] <= 1'b1;
            end
            rd_vld_reg <= fwd ? 1'b1 : integ_vld_reg[rd_addr];
        end
    end

    // integrator step: count up to the limit on a one, down to zero on a zero
    always_comb begin
        integ_cur = rd_vld_reg ? rd_data_reg : '0;
        up_sum    = {{(TIMER_W + 1 - WORD_W){1'b0}}, integ_cur} + {1'b0, s1_dt_reg};
        hit_limit = (up_sum >= {{(TIMER_W + 1 - WORD_W){1'b0}}, s1_limit_reg});
        hit_zero  = (s1_dt_reg >= {{(TIMER_W - WORD_W){1'b0}}, integ_cur});
        filt_next = filt_reg;
        if (s1_bit_reg) begin
            if (hit_limit) begin
                integ_new = s1_limit_reg;
                filt_next[WORD_IDX_W'(s1_pos_reg)] = 1'b1;
            end else begin
                integ_new = up_sum[WORD_W-1:0];
            end
        end else begin
            if (hit_zero) begin
                integ_new = '0;
                filt_next[WORD_IDX_W'(s1_pos_reg)] = 1'b0;
            end else begin
                integ_new = integ_cur - s1_dt_reg[WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg <= '0;
        end else if (wr_en) begin
            filt_reg <= filt_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (wr_en && s1_last_reg) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && s1_last_reg) begin
            m_tdata_reg <= {filt_next, s1_dout_reg};
        end
    end

endmodule

### rtl/iid_checker.sv
// port-level checks for the debounce block and their bind
`include "integrating_input_debounce_top_defines.svh"

module iid_checker #(
    parameter int CHANNEL_BYTES = 3,
    parameter int BITS_PER_BYTE = 8
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [iid_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import iid_pkg::*;

    localparam int NPOS_RAW  = CHANNEL_BYTES * BITS_PER_BYTE;
    localparam bit MULTI_BIT = (NPOS_RAW > 1);

    // a held result stays offered
    `IID_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    // a held result keeps its data
    `IID_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")
    // with more than one bit per word a take closes the input in the next cycle
    `IID_ASSERT(a_no_double_take, MULTI_BIT && s_tvalid && s_tready |=> !s_tready, "word taken during sweep")
    // out of reset the block is ready with nothing to deliver
    `IID_ASSERT_RST(a_reset_state, !aresetn |=> s_tready && !m_tvalid, "bad state after reset")

endmodule

bind integrating_input_debounce_top iid_checker #(
    .CHANNEL_BYTES (CHANNEL_BYTES),
    .BITS_PER_BYTE (BITS_PER_BYTE)
) u_iid_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### bench/integrating_input_debounce_top_test.sv
// self-checking bench for the integrating input debounce block
module integrating_input_debounce_top_test;
    import iid_pkg::*;

    localparam int NUM_BYTES       = 3;
    localparam int BYTE_BITS       = 8;
    // one bit integrated per cycle when the result does not stall, plus slack for the output register
    localparam int SWEEP_CYCLES    = NUM_BYTES * BYTE_BITS + 4;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int NUM_PHASES      = 5;
    localparam int MAX_REPORTS     = 10;

    // same layout as s_tdata: timer_count lowest, dout_data highest
    typedef struct packed {
        logic [WORD_W-1:0]  dout_data;
        logic [WORD_W-1:0]  raw_din;
        logic [TIMER_W-1:0] timer_count;
    } exchange_t;

    // same layout as m_tdata: dout_tx lowest
    typedef struct packed {
        logic [WORD_W-1:0] din_filtered;
        logic [WORD_W-1:0] dout_tx;
    } chain_result_t;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // timer_count, raw_din, dout_data
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b1;
    // dout_tx, din_filtered
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    integrating_input_debounce_top #(
        .CHANNEL_BYTES (NUM_BYTES),
        .BITS_PER_BYTE (BYTE_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: register copies and the filter state of the chain
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]  din_invert;
    logic [WORD_W-1:0]  dout_invert;
    logic [WORD_W-1:0]  hold_limit [NUM_BYTES];
    logic [WORD_W-1:0]  integ_level [WORD_W];
    logic [WORD_W-1:0]  filtered_word;
    logic [WORD_W-1:0]  prev_raw;
    logic [TIMER_W-1:0] prev_timer;

    exchange_t     pending_words [$];     // words waiting for the driver
    chain_result_t expected_results [$];  // predicted results, oldest first
    idle_mode_t    idle_mode = IDLE_NONE;
    int            failures  = 0;

    // stimulus generator state: running timer and the slowly changing input level
    logic [TIMER_W-1:0] gen_timer;
    logic [WORD_W-1:0]  held_level;

    // one exchange of the chain: integrate the word captured last time,
    // then remember this word's raw inputs for the next exchange
    function automatic chain_result_t integrate_exchange(exchange_t x);
        logic [TIMER_W-1:0] dt;
        logic [WORD_W-1:0]  word;
        logic [TIMER_W:0]   sum;
        logic [WORD_W-1:0]  limit;
        chain_result_t      r;
        dt = x.timer_count - prev_timer;      // wraps modulo 2^32
        word = prev_raw ^ din_invert;
        prev_timer = x.timer_count;
        for (int pos = 0; pos < WORD_W; pos++) begin
            limit = hold_limit[pos / BYTE_BITS];
            if (word[pos]) begin
                // wide sum so a huge elapsed time cannot wrap past the limit
                sum = {1'b0, dt} + integ_level[pos];
                if (sum >= limit) begin
                    integ_level[pos] = limit;
                    filtered_word[pos] = 1'b1;
                end else begin
                    integ_level[pos] = sum[WORD_W-1:0];
                end
            end else if (dt >= integ_level[pos]) begin
                integ_level[pos] = '0;
                filtered_word[pos] = 1'b0;
            end else begin
                integ_level[pos] = integ_level[pos] - dt[WORD_W-1:0];
            end
        end
        prev_raw = x.raw_din;
        r.dout_tx = x.dout_data ^ dout_invert;
        r.din_filtered = filtered_word;
        return r;
    endfunction

    function automatic bit sender_gap();
        unique case (idle_mode)
            IDLE_SENDER: return $urandom_range(99, 0) < 83;
            IDLE_BOTH:   return $urandom_range(99, 0) < 29;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        unique case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(99, 0) < 83;
            IDLE_BOTH:     return $urandom_range(99, 0) < 29;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic void flag_failure(string what);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("mismatch: %s", what);
    endfunction

    // ------------------------------------------------------------------
    // driver: offers pending words, predicts each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(integrate_exchange(s_tdata));
            // a held word keeps tvalid high; only one assignment per edge
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() > 0 && !sender_gap()) begin
                    s_tdata  <= pending_words.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side backpressure
    always @(posedge aclk) begin
        m_tready <= !receiver_stall();
    end

    // ------------------------------------------------------------------
    // monitor: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        chain_result_t got;
        chain_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_results.size() == 0) begin
                flag_failure($sformatf("result %h with nothing expected", got));
            end else begin
                want = expected_results.pop_front();
                if (got.dout_tx !== want.dout_tx)
                    flag_failure($sformatf("dout_tx expected %h got %h",
                                           want.dout_tx, got.dout_tx));
                if (got.din_filtered !== want.din_filtered)
                    flag_failure($sformatf("din_filtered expected %h got %h",
                                           want.din_filtered, got.din_filtered));
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_exchange(logic [TIMER_W-1:0] timer_count,
                                  logic [WORD_W-1:0] raw_din,
                                  logic [WORD_W-1:0] dout_data);
        exchange_t x;
        x.timer_count = timer_count;
        x.raw_din     = raw_din;
        x.dout_data   = dout_data;
        gen_timer     = timer_count;
        pending_words.push_back(x);
    endtask

    // mostly a stable level with occasional edges and bounces, timer steps
    // scaled to the hold limits so the integrators actually reach them
    task automatic queue_random_exchanges(int count);
        logic [WORD_W-1:0]  lim;
        logic [TIMER_W-1:0] step;
        logic [WORD_W-1:0]  raw;
        int                 pick;
        for (int n = 0; n < count; n++) begin
            lim  = hold_limit[$urandom_range(NUM_BYTES - 1, 0)];
            pick = $urandom_range(99, 0);
            if (pick < 6)
                step = '0;                               // no time passed
            else if (pick < 12)
                step = $urandom;                         // long gap, timer wraps
            else if (pick < 20)
                step = TIMER_W'(lim);                    // lands right on the limit
            else
                step = $urandom_range(lim / 2 + 1, 0);
            if ($urandom_range(9, 0) == 0)
                held_level ^= WORD_W'($urandom & $urandom & $urandom);  // a few inputs change
            raw  = held_level;
            pick = $urandom_range(99, 0);
            if (pick < 10)
                raw = WORD_W'($urandom);                 // noise
            else if (pick < 25)
                raw ^= WORD_W'($urandom & $urandom & $urandom);  // contact bounce
            queue_exchange(gen_timer + step, raw, WORD_W'($urandom));
        end
    endtask

    // sender holds off until every predicted result has come back
    task automatic drain_chain();
        while (pending_words.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (SWEEP_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        unique case (addr)
            REG_DIN_INVERT:  din_invert    = value;
            REG_DOUT_INVERT: dout_invert   = value;
            REG_HOLD_BYTE0:  hold_limit[0] = value;
            REG_HOLD_BYTE1:  hold_limit[1] = value;
            REG_HOLD_BYTE2:  hold_limit[2] = value;
            default: ;  // unused index, the block ignores it
        endcase
    endtask

    task automatic write_all(logic [WORD_W-1:0] din_inv, logic [WORD_W-1:0] dout_inv,
                             logic [WORD_W-1:0] hold0, logic [WORD_W-1:0] hold1,
                             logic [WORD_W-1:0] hold2);
        write_reg(REG_DIN_INVERT,  din_inv);
        write_reg(REG_DOUT_INVERT, dout_inv);
        write_reg(REG_HOLD_BYTE0,  hold0);
        write_reg(REG_HOLD_BYTE1,  hold1);
        write_reg(REG_HOLD_BYTE2,  hold2);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        din_invert    = '0;
        dout_invert   = '0;
        for (int b = 0; b < NUM_BYTES; b++)
            hold_limit[b] = HOLD_DEFAULT;
        for (int p = 0; p < WORD_W; p++)
            integ_level[p] = '0;
        filtered_word = '0;
        prev_raw      = '0;
        prev_timer    = '0;
        gen_timer     = '0;
        held_level    = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words under the reset settings
        queue_exchange(32'd0,          24'hFFFFFF, 24'h000000); // zero elapsed on empty integrators
        queue_exchange(32'd250000,     24'hFFFFFF, 24'hFFFFFF); // first word in only now
        queue_exchange(32'd749999,     24'hFFFFFF, 24'h5A5A5A); // step past the limit, up count clamps
        queue_exchange(32'd750000,     24'hFFFFFF, 24'hA5A5A5); // one more tick while already at the limit
        queue_exchange(32'hFFFFFFFF,   24'h000000, 24'h000000); // huge step, up count clamps
        queue_exchange(32'd4,          24'h555555, 24'hFFFFFF); // timer wraps, small down count
        queue_exchange(32'd499999,     24'hAAAAAA, 24'h123456); // down count lands on zero
        queue_exchange(32'd499999,     24'h000000, 24'h654321); // no time passed
        queue_exchange(32'd999999,     24'h0000FF, 24'h00FF00);
        queue_exchange(32'd1299999,    24'h00FF00, 24'hFF0000);
        queue_exchange(32'd1599999,    24'hFF0000, 24'h0000FF);
        queue_exchange(32'd2100000,    24'hFFFFFF, 24'hFFFFFF);
        queue_exchange(32'd2600000,    24'hFFFFFF, 24'h000000);
        queue_exchange(32'd3100000,    24'h000000, 24'hFFFFFF);
        queue_exchange(32'd3100001,    24'h000000, 24'h800001); // one tick down from the limit
        queue_exchange(32'h80000000,   24'h800001, 24'h7FFFFE); // long gap clears everything
        queue_exchange(32'h80000001,   24'h7FFFFE, 24'h000000);
        queue_exchange(32'h00000000,   24'hFFFFFF, 24'hFFFFFF); // wrap to zero
        queue_exchange(32'h00000000,   24'h000000, 24'h000000);
        drain_chain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            unique case (ph)
                0: begin
                    // zero, one and full-scale limits, all inputs inverted
                    write_all(24'hFFFFFF, 24'h000000, 24'd0, 24'd1, 24'hFFFFFF);
                    for (int a = int'(REG_HOLD_BYTE2) + 1; a < (1 << CFG_ADDR_W); a++)
                        write_reg(CFG_ADDR_W'(a), CFG_DATA_W'($urandom));
                    idle_mode = IDLE_SENDER;
                end
                1: begin
                    write_all(WORD_W'($urandom), 24'hFFFFFF, HOLD_DEFAULT, 24'd20000, 24'd3000);
                    idle_mode = IDLE_RECEIVER;
                end
                2: begin
                    write_all(24'h000000, WORD_W'($urandom), 24'hFFFFFF, 24'hFFFFFF,
                              24'hFFFFFF);
                    idle_mode = IDLE_BOTH;
                end
                3: begin
                    // limits drop far below what the integrators hold now
                    write_all(WORD_W'($urandom), WORD_W'($urandom),
                              WORD_W'($urandom_range(5000, 0)),
                              WORD_W'($urandom_range(5000, 0)),
                              WORD_W'($urandom_range(5000, 0)));
                    idle_mode = IDLE_NONE;
                end
                default: begin
                    write_all(WORD_W'($urandom), WORD_W'($urandom),
                              WORD_W'($urandom_range(24'hFFFFFF, 0)),
                              WORD_W'($urandom_range(24'hFFFFFF, 0)),
                              WORD_W'($urandom_range(24'hFFFFFF, 0)));
                    idle_mode = IDLE_BOTH;
                end
            endcase
            // pause halfway so the block empties out in the middle of each setting
            queue_random_exchanges(ITEMS_PER_PHASE / 2);
            drain_chain();
            queue_random_exchanges(ITEMS_PER_PHASE / 2);
            drain_chain();
        end

        if (failures == 0 && expected_results.size() == 0) begin
            $display("PASS integrating_input_debounce_top");
        end else begin
            $display("FAIL integrating_input_debounce_top");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #8000000;
        $display("FAIL integrating_input_debounce_top");
        $finish;
    end

endmodule
